/* hdl/srv_pkg.sv */
// ----------------------------------------------------------------------------
// srv_pkg
// Shared types, constants and the byte-wide CRC-32 step for the settings
// record validator.
// ----------------------------------------------------------------------------
`default_nettype none

package srv_pkg;

	localparam int unsigned RecBytes   = 32;
	localparam int unsigned CrcSpan    = 28;
	localparam int unsigned StepLimit  = 8;
	localparam int unsigned PosW       = $clog2(RecBytes);
	localparam int unsigned CfgIdxW    = 3;
	localparam int unsigned CfgDataW   = 64;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	localparam logic [PosW-1:0] POS_VERSION  = PosW'(4);
	localparam logic [PosW-1:0] POS_SIZE     = PosW'(6);
	localparam logic [PosW-1:0] POS_SEQUENCE = PosW'(8);
	localparam logic [PosW-1:0] POS_FREQ     = PosW'(12);
	localparam logic [PosW-1:0] POS_STEP     = PosW'(20);
	localparam logic [PosW-1:0] POS_AUTO     = PosW'(21);
	localparam logic [PosW-1:0] POS_RESERVED = PosW'(22);
	localparam logic [PosW-1:0] POS_TAIL     = PosW'(24);
	localparam logic [PosW-1:0] POS_CRC      = PosW'(28);
	localparam logic [PosW-1:0] POS_LAST     = PosW'(RecBytes - 1);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SIGNATURE = 3'd1,
		ST_VERSION   = 3'd2,
		ST_SIZE      = 3'd3,
		ST_TAIL      = 3'd4,
		ST_CRC       = 3'd5,
		ST_RANGE     = 3'd6,
		ST_STEP      = 3'd7
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SIGNATURE = 3'd0,
		CFG_VERSION   = 3'd1,
		CFG_TAIL      = 3'd2,
		CFG_MIN_FREQ  = 3'd3,
		CFG_MAX_FREQ  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] signature;
		logic [15:0] version;
		logic [31:0] tail;
		logic [63:0] min_freq;
		logic [63:0] max_freq;
	} cfg_t;

	typedef struct packed {
		logic [31:0] signature;
		logic [15:0] version;
		logic [15:0] size;
		logic [31:0] sequence_no;
		logic [63:0] frequency;
		logic [7:0]  step;
		logic [7:0]  auto_step;
		logic [31:0] tail;
		logic [31:0] crc_calc;
		logic [31:0] crc_stored;
	} rec_t;

	function automatic logic [31:0] crc_byte(logic [31:0] acc, logic [7:0] b);
		logic [31:0] c;
		c = acc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/settings_record_validator.sv */
// ----------------------------------------------------------------------------
// settings_record_validator
// Checks a 32-byte little-endian settings record streamed a byte per word:
// CRC-32 over bytes 0..27, field capture, ordered checks, one result word.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid / in_stall    record_byte
//  out      out  out_valid / out_stall  status, record_sequence,
//                                       record_frequency, record_step,
//                                       record_auto_step
//  cfg      in   cfg_we                 cfg_index, cfg_data
//
//  One byte per cycle sustained while in_stall is low; the last byte passes
//  the input stage, its checks then load the result register once it is free.
//  in_stall rises only while the last byte of a record waits for a stalled
//  result register. Reset clears position counter and valid flags, presets CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module settings_record_validator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [srv_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [srv_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    record_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [2:0]                         status,
	output logic [31:0]                        record_sequence,
	output logic [63:0]                        record_frequency,
	output logic [7:0]                         record_step,
	output logic [7:0]                         record_auto_step
);

	srv_pkg::cfg_t cfg;
	srv_pkg::rec_t rec;
	logic          take_ok;
	logic          rec_fire;

	srv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	srv_collector u_collector (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.record_byte (record_byte),
		.take_ok     (take_ok),
		.rec_fire    (rec_fire),
		.rec         (rec)
	);

	srv_judge u_judge (
		.clk              (clk),
		.arst_n           (arst_n),
		.rec_fire         (rec_fire),
		.rec              (rec),
		.cfg              (cfg),
		.take_ok          (take_ok),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.record_sequence  (record_sequence),
		.record_frequency (record_frequency),
		.record_step      (record_step),
		.record_auto_step (record_auto_step)
	);

endmodule

`default_nettype wire

/* hdl/srv_cfg.sv */
// ----------------------------------------------------------------------------
// srv_cfg
// Configuration registers: expected signature, version, tail magic and the
// frequency window.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [srv_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [srv_pkg::CfgDataW-1:0]  cfg_data,
	output srv_pkg::cfg_t                      cfg
);

	srv_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signature <= '0;
			cfg_q.version   <= '0;
			cfg_q.tail      <= '0;
			cfg_q.min_freq  <= '0;
			cfg_q.max_freq  <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				srv_pkg::CFG_SIGNATURE: cfg_q.signature <= cfg_data[31:0];
				srv_pkg::CFG_VERSION:   cfg_q.version   <= cfg_data[15:0];
				srv_pkg::CFG_TAIL:      cfg_q.tail      <= cfg_data[31:0];
				srv_pkg::CFG_MIN_FREQ:  cfg_q.min_freq  <= cfg_data;
				srv_pkg::CFG_MAX_FREQ:  cfg_q.max_freq  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* hdl/srv_collector.sv */
// ----------------------------------------------------------------------------
// srv_collector
// Input register, byte position counter, field capture and running CRC.
// Presents the completed record while the last byte sits in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_collector (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  record_byte,
	input  wire logic        take_ok,
	output logic             rec_fire,
	output srv_pkg::rec_t    rec
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic [srv_pkg::PosW-1:0]    pos_q;
	logic [31:0]                 crc_q;
	srv_pkg::rec_t               fld_q;
	srv_pkg::rec_t               fld_d;
	logic                        last;
	logic                        advance;
	logic [2:0]                  freq_lane;

	assign last     = (pos_q == srv_pkg::POS_LAST);
	assign advance  = !valid_s1 || !last || take_ok;
	assign in_stall = !advance;
	assign rec_fire = valid_s1 && last && take_ok;
	assign freq_lane = 3'(pos_q - srv_pkg::POS_FREQ);

	always_comb begin
		fld_d = fld_q;
		if (pos_q < srv_pkg::POS_VERSION) begin
			fld_d.signature[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
		end else if (pos_q < srv_pkg::POS_SIZE) begin
			fld_d.version[{pos_q[0], 3'b000} +: 8] = byte_s1;
		end else if (pos_q < srv_pkg::POS_SEQUENCE) begin
			fld_d.size[{pos_q[0], 3'b000} +: 8] = byte_s1;
		end else if (pos_q < srv_pkg::POS_FREQ) begin
			fld_d.sequence_no[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
		end else if (pos_q < srv_pkg::POS_STEP) begin
			fld_d.frequency[{freq_lane, 3'b000} +: 8] = byte_s1;
		end else if (pos_q == srv_pkg::POS_STEP) begin
			fld_d.step = byte_s1;
		end else if (pos_q == srv_pkg::POS_AUTO) begin
			fld_d.auto_step = byte_s1;
		end else if (pos_q < srv_pkg::POS_TAIL) begin
			fld_d.step = fld_q.step;
		end else if (pos_q < srv_pkg::POS_CRC) begin
			fld_d.tail[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
		end else begin
			fld_d.crc_stored[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
		end
		fld_d.crc_calc = crc_q ^ srv_pkg::CRC_ONES;
	end

	assign rec = fld_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			byte_s1 <= record_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= srv_pkg::CRC_ONES;
		end else if (valid_s1 && advance) begin
			pos_q <= pos_q + 1'b1;
			if (last) begin
				crc_q <= srv_pkg::CRC_ONES;
			end else if (pos_q < srv_pkg::POS_CRC) begin
				crc_q <= srv_pkg::crc_byte(crc_q, byte_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			fld_q <= fld_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/srv_judge.sv */
// ----------------------------------------------------------------------------
// srv_judge
// Ordered record checks and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_judge (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           rec_fire,
	input  wire srv_pkg::rec_t  rec,
	input  wire srv_pkg::cfg_t  cfg,
	output logic                take_ok,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [2:0]          status,
	output logic [31:0]         record_sequence,
	output logic [63:0]         record_frequency,
	output logic [7:0]          record_step,
	output logic [7:0]          record_auto_step
);

	srv_pkg::status_t  st_d;
	logic              out_valid_q;
	srv_pkg::status_t  status_q;
	logic [31:0]       seq_q;
	logic [63:0]       freq_q;
	logic [7:0]        step_q;
	logic [7:0]        auto_q;

	always_comb begin
		if (rec.signature != cfg.signature) begin
			st_d = srv_pkg::ST_SIGNATURE;
		end else if (rec.version != cfg.version) begin
			st_d = srv_pkg::ST_VERSION;
		end else if (rec.size != 16'(srv_pkg::RecBytes)) begin
			st_d = srv_pkg::ST_SIZE;
		end else if (rec.tail != cfg.tail) begin
			st_d = srv_pkg::ST_TAIL;
		end else if (rec.crc_calc != rec.crc_stored) begin
			st_d = srv_pkg::ST_CRC;
		end else if (rec.frequency < cfg.min_freq || rec.frequency > cfg.max_freq) begin
			st_d = srv_pkg::ST_RANGE;
		end else if (rec.step >= 8'(srv_pkg::StepLimit)) begin
			st_d = srv_pkg::ST_STEP;
		end else begin
			st_d = srv_pkg::ST_OK;
		end
	end

	assign take_ok = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_fire) begin
			status_q <= st_d;
			seq_q    <= rec.sequence_no;
			freq_q   <= rec.frequency;
			step_q   <= rec.step;
			auto_q   <= rec.auto_step;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign record_sequence  = seq_q;
	assign record_frequency = freq_q;
	assign record_step      = step_q;
	assign record_auto_step = auto_q;

endmodule

`default_nettype wire

/* hdl/srv_checker.sv */
// ----------------------------------------------------------------------------
// srv_checker
// Port-level checks for the settings record validator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [7:0]                    record_byte,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [2:0]                    status,
	input  wire logic [31:0]                   record_sequence,
	input  wire logic [63:0]                   record_frequency,
	input  wire logic [7:0]                    record_step,
	input  wire logic [7:0]                    record_auto_step
);

	logic [srv_pkg::PosW-1:0] cnt_q;
	logic [1:0]               pend_q;
	logic                     in_acc;
	logic                     out_acc;
	logic                     rec_done;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign rec_done = in_acc && (cnt_q == srv_pkg::POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= '0;
		end else begin
			if (in_acc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			pend_q <= pend_q + {1'b0, rec_done} - {1'b0, out_acc};
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(record_byte))
		else $error("input word changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(record_sequence) && $stable(record_frequency)
			&& $stable(record_step) && $stable(record_auto_step))
		else $error("result word changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result word without a completed record");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && pend_q != 2'd0)
		else $error("input stalled while result path is free");

	a_ok_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == srv_pkg::ST_OK |-> record_step < 8'(srv_pkg::StepLimit))
		else $error("pass reported with step index out of range");

endmodule

bind settings_record_validator srv_checker u_srv_checker (.*);

`default_nettype wire

/* verif/settings_record_validator_tb.sv */
// ----------------------------------------------------------------------------
// settings_record_validator_tb
// Streams 32-byte settings records into the validator under several register
// settings, predicts each result word from its own CRC and field decode, and
// compares every result field. Random idling on both channels, one long
// output hold, mid-record register writes and out-of-map register indexes.
// ----------------------------------------------------------------------------
module settings_record_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srv_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int GOOD_PCT      = 70;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_FIRST = 3'd5;

	typedef enum int {
		FLAW_NONE,
		FLAW_SIGNATURE,
		FLAW_VERSION,
		FLAW_SIZE,
		FLAW_TAIL,
		FLAW_CRC,
		FLAW_LOW_FREQ,
		FLAW_HIGH_FREQ,
		FLAW_STEP,
		FLAW_NOISE,
		FLAW_SEVERAL
	} flaw_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] seq_no;
		logic [63:0] freq;
		logic [7:0]  step;
		logic [7:0]  auto_step;
	} verdict_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [7:0]          record_byte = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          status;
	logic [31:0]         record_sequence;
	logic [63:0]         record_frequency;
	logic [7:0]          record_step;
	logic [7:0]          record_auto_step;

	logic [7:0] pending_bytes[$];
	verdict_t   verdicts[$];

	cfg_t            regs;
	rec_t            seen;
	logic [PosW-1:0] rec_pos = '0;
	logic [31:0]     crc_run = CRC_ONES;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_served = 1'b0;
	int hold_left = 0;
	bit byte_accepted = 1'b0;
	int err_count = 0;
	int bytes_fed = 0;
	int records_checked = 0;
	int cycle_count = 0;
	int status_hits[8];

	settings_record_validator uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.record_byte      (record_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.record_sequence  (record_sequence),
		.record_frequency (record_frequency),
		.record_step      (record_step),
		.record_auto_step (record_auto_step)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// reflected CRC-32, one input bit per shift
	function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	task automatic absorb_byte(input logic [7:0] b);
		verdict_t v;
		status_t  st;
		if (rec_pos < CrcSpan) crc_run = crc_update(crc_run, b);
		if (rec_pos < POS_VERSION)
			seen.signature[8*rec_pos +: 8] = b;
		else if (rec_pos < POS_SIZE)
			seen.version[8*(rec_pos-POS_VERSION) +: 8] = b;
		else if (rec_pos < POS_SEQUENCE)
			seen.size[8*(rec_pos-POS_SIZE) +: 8] = b;
		else if (rec_pos < POS_FREQ)
			seen.sequence_no[8*(rec_pos-POS_SEQUENCE) +: 8] = b;
		else if (rec_pos < POS_STEP)
			seen.frequency[8*(rec_pos-POS_FREQ) +: 8] = b;
		else if (rec_pos == POS_STEP)
			seen.step = b;
		else if (rec_pos == POS_AUTO)
			seen.auto_step = b;
		else if (rec_pos >= POS_TAIL && rec_pos < POS_CRC)
			seen.tail[8*(rec_pos-POS_TAIL) +: 8] = b;
		else if (rec_pos >= POS_CRC)
			seen.crc_stored[8*(rec_pos-POS_CRC) +: 8] = b;

		if (rec_pos != POS_LAST) begin
			rec_pos++;
		end else begin
			if (seen.signature != regs.signature) st = ST_SIGNATURE;
			else if (seen.version != regs.version) st = ST_VERSION;
			else if (seen.size != 16'(RecBytes)) st = ST_SIZE;
			else if (seen.tail != regs.tail) st = ST_TAIL;
			else if ((crc_run ^ CRC_ONES) != seen.crc_stored) st = ST_CRC;
			else if (seen.frequency < regs.min_freq || seen.frequency > regs.max_freq)
				st = ST_RANGE;
			else if (seen.step >= StepLimit) st = ST_STEP;
			else st = ST_OK;
			v.status = st;
			v.seq_no = seen.sequence_no;
			v.freq = seen.frequency;
			v.step = seen.step;
			v.auto_step = seen.auto_step;
			verdicts.push_back(v);
			rec_pos = '0;
			crc_run = CRC_ONES;
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			err_count++;
			if (err_count <= 10)
				$display("mismatch in %s of result %0d: expected %0h, got %0h",
					name, records_checked, want, got);
		end
	endtask

	task automatic check_result();
		verdict_t want;
		if (verdicts.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("result word with nothing expected: status %0d", status);
		end else begin
			want = verdicts.pop_front();
			records_checked++;
			status_hits[status]++;
			compare_field("status", 64'(want.status), 64'(status));
			compare_field("record_sequence", 64'(want.seq_no), 64'(record_sequence));
			compare_field("record_frequency", want.freq, record_frequency);
			compare_field("record_step", 64'(want.step), 64'(record_step));
			compare_field("record_auto_step", 64'(want.auto_step), 64'(record_auto_step));
		end
	endtask

	always @(posedge clk) begin
		byte_accepted = in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) check_result();
			if (byte_accepted) begin
				bytes_fed++;
				absorb_byte(record_byte);
			end
		end
	end

	always @(negedge clk) begin
		if (!in_valid || byte_accepted) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				in_valid <= 1'b1;
				record_byte <= pending_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req && !hold_served) begin
			hold_left = HOLD_CYCLES;
			hold_served = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("settings_record_validator_tb: errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_SIGNATURE: regs.signature = val[31:0];
			CFG_VERSION:   regs.version = val[15:0];
			CFG_TAIL:      regs.tail = val[31:0];
			CFG_MIN_FREQ:  regs.min_freq = val;
			CFG_MAX_FREQ:  regs.max_freq = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_settings(input logic [31:0] sig, input logic [15:0] ver,
			input logic [31:0] tail, input logic [63:0] fmin, input logic [63:0] fmax);
		write_reg(CFG_SIGNATURE, 64'(sig));
		write_reg(CFG_VERSION, 64'(ver));
		write_reg(CFG_TAIL, 64'(tail));
		write_reg(CFG_MIN_FREQ, fmin);
		write_reg(CFG_MAX_FREQ, fmax);
	endtask

	// all bytes in, all results out, then let the pipeline settle
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [255:0] build_image(rec_t r, logic [15:0] rsv, bit crc_bad);
		logic [255:0] img;
		logic [31:0]  c;
		img = {32'd0, r.tail, rsv, r.auto_step, r.step, r.frequency, r.sequence_no,
			r.size, r.version, r.signature};
		c = CRC_ONES;
		for (int i = 0; i < CrcSpan; i++) c = crc_update(c, img[8*i +: 8]);
		img[255:224] = c ^ CRC_ONES ^ (crc_bad ? (32'd1 << $urandom_range(31)) : 32'd0);
		return img;
	endfunction

	function automatic rec_t well_formed();
		rec_t        r;
		logic [63:0] rnd;
		logic [63:0] span;
		rnd = {$urandom, $urandom};
		r = '0;
		r.signature = regs.signature;
		r.version = regs.version;
		r.size = 16'(RecBytes);
		r.sequence_no = $urandom;
		r.step = 8'($urandom_range(StepLimit - 1));
		r.auto_step = 8'($urandom);
		r.tail = regs.tail;
		case ($urandom_range(3))
			0: r.frequency = regs.min_freq;
			1: r.frequency = regs.max_freq;
			default: begin
				span = regs.max_freq - regs.min_freq;
				if (regs.min_freq > regs.max_freq || span == '1)
					r.frequency = rnd;
				else
					r.frequency = regs.min_freq + rnd % (span + 64'd1);
			end
		endcase
		return r;
	endfunction

	task automatic apply_flaw(inout rec_t r, inout bit crc_bad, input flaw_t f);
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		case (f)
			FLAW_SIGNATURE: r.signature ^= 32'd1 << $urandom_range(31);
			FLAW_VERSION:   r.version ^= 16'd1 << $urandom_range(15);
			FLAW_SIZE:      r.size ^= 16'd1 << $urandom_range(15);
			FLAW_TAIL:      r.tail ^= 32'd1 << $urandom_range(31);
			FLAW_CRC:       crc_bad = 1'b1;
			FLAW_LOW_FREQ: begin
				if (regs.min_freq != '0) r.frequency = rnd % regs.min_freq;
			end
			FLAW_HIGH_FREQ: begin
				if (regs.max_freq != '1)
					r.frequency = regs.max_freq + 64'd1 + rnd % ~regs.max_freq;
			end
			FLAW_STEP:      r.step = 8'($urandom_range(255, StepLimit));
			default: ;
		endcase
	endtask

	task automatic push_image(input logic [255:0] img, input int first, input int last);
		for (int i = first; i <= last; i++) pending_bytes.push_back(img[8*i +: 8]);
	endtask

	task automatic queue_random_record();
		rec_t         r;
		bit           crc_bad;
		flaw_t        f;
		logic [255:0] img;
		r = well_formed();
		crc_bad = 1'b0;
		if ($urandom_range(99) < GOOD_PCT) f = FLAW_NONE;
		else f = flaw_t'($urandom_range(FLAW_SEVERAL, FLAW_SIGNATURE));
		if (f == FLAW_NOISE) begin
			for (int i = 0; i < 8; i++) img[32*i +: 32] = $urandom;
		end else begin
			if (f == FLAW_SEVERAL) begin
				repeat ($urandom_range(3, 2))
					apply_flaw(r, crc_bad, flaw_t'($urandom_range(FLAW_STEP, FLAW_SIGNATURE)));
			end else begin
				apply_flaw(r, crc_bad, f);
			end
			img = build_image(r, 16'($urandom), crc_bad);
		end
		push_image(img, 0, RecBytes - 1);
	endtask

	task automatic run_random(input int n_records, input int gap_pct, input int stall_pct);
		send_gap_pct <= gap_pct;
		recv_stall_pct <= stall_pct;
		repeat (n_records) queue_random_record();
		wait_idle();
	endtask

	task automatic run_directed();
		rec_t r;
		r = well_formed();
		r.frequency = regs.min_freq;
		r.step = '0;
		r.auto_step = '0;
		r.sequence_no = '0;
		push_image(build_image(r, 16'h0000, 1'b0), 0, RecBytes - 1);
		r = well_formed();
		r.frequency = regs.max_freq;
		r.step = 8'(StepLimit - 1);
		r.auto_step = '1;
		r.sequence_no = '1;
		push_image(build_image(r, 16'hFFFF, 1'b0), 0, RecBytes - 1);
		// every check broken: signature must win
		r = well_formed();
		r.signature = ~regs.signature;
		r.version = ~regs.version;
		r.size = '1;
		r.tail = ~regs.tail;
		r.frequency = regs.max_freq + 64'd1;
		r.step = '1;
		push_image(build_image(r, 16'h1234, 1'b1), 0, RecBytes - 1);
		r = well_formed();
		r.version ^= 16'h8000;
		r.size = '0;
		r.tail = '0;
		r.step = 8'(StepLimit);
		push_image(build_image(r, 16'h0000, 1'b0), 0, RecBytes - 1);
		// size with swapped bytes
		r = well_formed();
		r.size = 16'h2000;
		r.tail ^= 32'd1;
		push_image(build_image(r, 16'h0000, 1'b0), 0, RecBytes - 1);
		r = well_formed();
		r.tail ^= 32'h8000_0000;
		push_image(build_image(r, 16'h0000, 1'b1), 0, RecBytes - 1);
		r = well_formed();
		push_image(build_image(r, 16'h5AA5, 1'b1), 0, RecBytes - 1);
		r = well_formed();
		r.frequency = regs.min_freq - 64'd1;
		push_image(build_image(r, 16'h0000, 1'b0), 0, RecBytes - 1);
		r = well_formed();
		r.frequency = regs.max_freq + 64'd1;
		r.step = 8'(StepLimit);
		push_image(build_image(r, 16'h0000, 1'b0), 0, RecBytes - 1);
		r = well_formed();
		r.step = 8'(StepLimit);
		push_image(build_image(r, 16'h0000, 1'b0), 0, RecBytes - 1);
		r = well_formed();
		r.step = '1;
		push_image(build_image(r, 16'h0000, 1'b0), 0, RecBytes - 1);
		push_image('0, 0, RecBytes - 1);
		push_image('1, 0, RecBytes - 1);
		wait_idle();
	endtask

	initial begin
		rec_t         r;
		logic [255:0] img;
		logic [63:0]  fmin;

		regs = '0;
		regs.max_freq = '1;
		seen = '0;
		foreach (status_hits[i]) status_hits[i] = 0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset register values, full frequency range
		r = well_formed();
		r.frequency = '0;
		push_image(build_image(r, 16'h0000, 1'b0), 0, RecBytes - 1);
		r = well_formed();
		r.frequency = '1;
		push_image(build_image(r, 16'hFFFF, 1'b0), 0, RecBytes - 1);
		queue_random_record();
		wait_idle();

		write_settings(32'h5E77_1A6B, 16'h0102, 32'hC0DE_F00D, 64'd1_000_000, 64'd225_000_000);
		run_directed();

		fmin = 64'($urandom);
		write_settings($urandom, 16'($urandom), $urandom, fmin,
			fmin + ({$urandom, $urandom} >> 1));
		for (int k = CFG_SPARE_FIRST; k < 2**CfgIdxW; k++)
			write_reg(CfgIdxW'(k), {$urandom, $urandom});
		run_random(3, 0, 0);

		// output held long enough to back the block up into its input
		repeat (4) queue_random_record();
		hold_req <= 1'b1;
		wait_idle();

		write_settings('1, '1, '1, 64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF);
		run_random(3, 58, 0);

		write_settings('0, '0, '0, '0, '0);
		run_random(3, 0, 58);

		// range registers change in the middle of a record
		r = well_formed();
		img = build_image(r, 16'($urandom), 1'b0);
		push_image(img, 0, 12);
		wait_idle();
		write_reg(CFG_MIN_FREQ, 64'hFFFF_FFFF_0000_0000);
		write_reg(CFG_MAX_FREQ, 64'h0000_0000_FFFF_FFFF);
		push_image(img, 13, RecBytes - 1);
		run_random(3, 6, 6);

		write_settings($urandom, 16'($urandom), $urandom, '1, '1);
		run_random(3, 58, 0);

		wait_idle();
		if (verdicts.size() != 0) begin
			err_count += verdicts.size();
			$display("%0d expected result words never arrived", verdicts.size());
		end
		$display("run covered %0d record bytes and %0d result words over seven register settings",
			bytes_fed, records_checked);
		$display("status mix: ok %0d sig %0d ver %0d size %0d tail %0d crc %0d range %0d step %0d",
			status_hits[ST_OK], status_hits[ST_SIGNATURE], status_hits[ST_VERSION],
			status_hits[ST_SIZE], status_hits[ST_TAIL], status_hits[ST_CRC],
			status_hits[ST_RANGE], status_hits[ST_STEP]);
		if (err_count == 0) begin
			$display("settings_record_validator_tb: clean");
		end else begin
			$display("settings_record_validator_tb: errors");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/srv_pkg.sv
hdl/srv_cfg.sv
hdl/srv_collector.sv
hdl/srv_judge.sv
hdl/settings_record_validator.sv
hdl/srv_checker.sv
verif/settings_record_validator_tb.sv
